// ----- sv/mctb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package mctb_pkg;
    localparam int DEF_NUM_TIMERS = 8;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_TICK  = 2'd2,
        OP_QUERY = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_FIRE  = 2'd0,
        KIND_REPLY = 2'd1,
        KIND_DONE  = 2'd2
    } kind_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_done;
    } dp_stat_t;
endpackage
`default_nettype wire

// ----- sv/mctb_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mctb_div
    import mctb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [32:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [32:0]      quotient,
    output logic [31:0]      remainder
);
    logic [32:0] quo_reg;
    logic [32:0] rem_reg;
    logic [31:0] dvs_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [33:0] trial;
    logic [32:0] rem_shift;

    assign rem_shift = {rem_reg[31:0], quo_reg[32]};
    assign trial     = {1'b0, rem_shift} - {2'b00, dvs_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd33;
            end
            else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg) begin
            if (!trial[33]) begin
                rem_reg <= trial[32:0];
                quo_reg <= {quo_reg[31:0], 1'b1};
            end
            else begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[31:0], 1'b0};
            end
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[31:0];
endmodule
`default_nettype wire

// ----- sv/mctb_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mctb_datapath
    import mctb_pkg::*;
#(
    parameter int NUM_TIMERS = DEF_NUM_TIMERS,
    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire dp_cmd_t       cmd,
    input  wire logic [IW-1:0] idx,
    input  wire logic [31:0]   delta,
    output dp_stat_t           stat,
    output logic               t_running,
    output logic               t_fires,
    output logic               t_notify,
    output logic               t_div,
    output logic [32:0]        t_count,
    output logic [31:0]        t_remaining,
    input  wire logic          wr_start,
    input  wire logic          wr_stop,
    input  wire logic [31:0]   wr_period,
    input  wire logic          wr_repeat,
    input  wire logic          wr_notify,
    output logic [31:0]        q_remaining
);
    logic [NUM_TIMERS-1:0] running_reg;
    logic [NUM_TIMERS-1:0] reload_reg;
    logic [NUM_TIMERS-1:0] notify_reg;
    logic [31:0]           timeout_reg [NUM_TIMERS];
    logic [31:0]           elapsed_reg [NUM_TIMERS];

    logic [31:0] per_reg;
    logic [32:0] sum_reg;
    logic        run_reg;
    logic        rld_reg;
    logic        ntf_reg;
    logic        run_next;
    logic [31:0] el_next;
    logic [32:0] cnt_next;
    logic        fire_next;
    logic [32:0] dq;
    logic [31:0] dr;
    logic        dbusy;
    logic        ddone;

    mctb_div u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
        .dividend(sum_reg), .divisor(per_reg),
        .busy(dbusy), .done(ddone), .quotient(dq), .remainder(dr)
    );

    assign stat.div_busy = dbusy;
    assign stat.div_done = ddone;

    always_ff @(posedge clk) begin
        if (cmd.load) begin
            per_reg <= timeout_reg[idx];
            sum_reg <= {1'b0, elapsed_reg[idx]} + {1'b0, delta};
            run_reg <= running_reg[idx];
            rld_reg <= reload_reg[idx];
            ntf_reg <= notify_reg[idx];
        end
    end

    assign t_div = run_reg && per_reg != '0 && sum_reg >= {1'b0, per_reg} && rld_reg;

    always_comb begin
        run_next  = run_reg;
        el_next   = sum_reg[31:0];
        cnt_next  = '0;
        if (run_reg) begin
            if (per_reg == '0 || (sum_reg >= {1'b0, per_reg} && !rld_reg)) begin
                cnt_next = 33'd1;
                run_next = 1'b0;
                el_next  = sum_reg[32] ? 32'hFFFF_FFFF : sum_reg[31:0];
            end
            else if (sum_reg >= {1'b0, per_reg}) begin
                cnt_next = dq;
                el_next  = dr;
            end
        end
        fire_next = cnt_next != '0;
    end

    assign t_running   = run_reg;
    assign t_fires     = fire_next;
    assign t_notify    = ntf_reg;
    assign t_count     = cnt_next;
    assign t_remaining = (run_next && el_next < per_reg) ? per_reg - el_next : '0;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            running_reg <= '0;
            reload_reg  <= '0;
            notify_reg  <= '0;
            for (int k = 0; k < NUM_TIMERS; k++) begin
                timeout_reg[k] <= '0;
                elapsed_reg[k] <= '0;
            end
        end
        else if (cmd.commit) begin
            running_reg[idx] <= run_next;
            elapsed_reg[idx] <= el_next;
        end
        else if (wr_start) begin
            running_reg[idx] <= 1'b1;
            reload_reg[idx]  <= wr_repeat;
            notify_reg[idx]  <= wr_notify;
            timeout_reg[idx] <= wr_period;
            elapsed_reg[idx] <= '0;
        end
        else if (wr_stop) begin
            running_reg[idx] <= 1'b0;
        end
    end

    // The reply reports the timer as it stands after the command.
    assign q_remaining = wr_start ? wr_period :
                         (!wr_stop && running_reg[idx] && elapsed_reg[idx] < timeout_reg[idx])
                         ? timeout_reg[idx] - elapsed_reg[idx] : '0;
endmodule
`default_nettype wire

// ----- sv/mctb_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mctb_ctrl
    import mctb_pkg::*;
#(
    parameter int NUM_TIMERS = DEF_NUM_TIMERS,
    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [1:0]    in_op,
    input  wire logic [7:0]    in_id,
    input  wire logic [31:0]   in_delta,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [73:0]        out_data,
    output kind_t              out_kind,
    output logic               out_last,
    output dp_cmd_t            cmd,
    input  wire dp_stat_t      stat,
    output logic [IW-1:0]      idx,
    output logic [31:0]        delta,
    input  wire logic          t_running,
    input  wire logic          t_fires,
    input  wire logic          t_notify,
    input  wire logic          t_div,
    input  wire logic [32:0]   t_count,
    input  wire logic [31:0]   t_remaining,
    output logic               wr_start,
    output logic               wr_stop,
    input  wire logic [31:0]   q_remaining
);
    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_EVAL, S_DIVW, S_OUT, S_DONE
    } state_t;

    localparam logic [8:0] NT = 9'(NUM_TIMERS);

    state_t      state_reg;
    logic [IW:0] idx_reg;
    logic [31:0] delta_reg;
    logic        ovalid_reg;
    logic [73:0] odata_reg;
    kind_t       okind_reg;
    logic        olast_reg;
    logic        accept;
    logic        bad;
    logic        slot_free;
    logic        out_load;
    logic [IW:0] idx_inc;

    assign slot_free = !ovalid_reg || out_ready;
    assign in_ready  = state_reg == S_IDLE && slot_free;
    assign accept    = in_valid && in_ready;
    assign bad       = {1'b0, in_id} >= NT;
    assign idx       = accept ? in_id[IW-1:0] : idx_reg[IW-1:0];
    assign delta     = delta_reg;
    assign wr_start  = accept && !bad && opcode_t'(in_op) == OP_START;
    assign wr_stop   = accept && !bad && opcode_t'(in_op) == OP_STOP;
    assign idx_inc   = idx_reg + 1'b1;
    assign out_load  = (state_reg == S_IDLE && accept && opcode_t'(in_op) != OP_TICK) ||
                       (state_reg inside {S_OUT, S_DONE} && slot_free);

    assign cmd.load      = state_reg == S_LOAD;
    assign cmd.div_start = state_reg == S_EVAL && t_div;
    assign cmd.commit    = (state_reg == S_EVAL && !t_div) ||
                           (state_reg == S_DIVW && stat.div_done);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            delta_reg  <= '0;
            ovalid_reg <= 1'b0;
            odata_reg  <= '0;
            okind_reg  <= KIND_FIRE;
            olast_reg  <= 1'b0;
        end
        else begin
            if (ovalid_reg && out_ready && !out_load) ovalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (accept && opcode_t'(in_op) == OP_TICK) begin
                        idx_reg   <= '0;
                        delta_reg <= in_delta;
                        state_reg <= S_LOAD;
                    end
                    else if (accept) begin
                        ovalid_reg <= 1'b1;
                        olast_reg  <= 1'b1;
                        okind_reg  <= KIND_REPLY;
                        odata_reg  <= {bad, bad ? 32'd0 : q_remaining, 33'd0, in_id};
                    end
                end
                S_LOAD: state_reg <= S_EVAL;
                S_EVAL: begin
                    if (t_div) state_reg <= S_DIVW;
                    else if (t_running && t_fires && t_notify) state_reg <= S_OUT;
                    else begin
                        idx_reg   <= idx_inc;
                        state_reg <= (idx_inc == NT[IW:0]) ? S_DONE : S_LOAD;
                    end
                end
                S_DIVW: begin
                    if (stat.div_done) begin
                        if (t_notify) state_reg <= S_OUT;
                        else begin
                            idx_reg   <= idx_inc;
                            state_reg <= (idx_inc == NT[IW:0]) ? S_DONE : S_LOAD;
                        end
                    end
                end
                S_OUT: begin
                    if (slot_free) begin
                        ovalid_reg <= 1'b1;
                        olast_reg  <= 1'b0;
                        okind_reg  <= KIND_FIRE;
                        odata_reg  <= {1'b0, t_remaining, t_count, 8'(idx_reg[IW-1:0])};
                        idx_reg    <= idx_inc;
                        state_reg  <= (idx_inc == NT[IW:0]) ? S_DONE : S_LOAD;
                    end
                end
                S_DONE: begin
                    if (slot_free) begin
                        ovalid_reg <= 1'b1;
                        olast_reg  <= 1'b1;
                        okind_reg  <= KIND_DONE;
                        odata_reg  <= '0;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;
    assign out_kind  = okind_reg;
    assign out_last  = olast_reg;
endmodule
`default_nettype wire

// ----- sv/multi_channel_timer_bank.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A bank of NUM_TIMERS timers. Start, stop and query each give one reply.
// A tick visits every timer in turn: each timer is loaded (S_LOAD) and evaluated (S_EVAL),
// goes on to S_OUT when it reports an event, and waits in S_DIVW for a repeating timer that
// expires, since its fire count and remainder come from a shared radix-2 divider doing one
// quotient bit per cycle; a stalled output holds the tick in S_OUT or S_DONE.
module multi_channel_timer_bank
    import mctb_pkg::*;
#(
    parameter int NUM_TIMERS = DEF_NUM_TIMERS,
    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // timer_id, period, repeat_mode, notify_enable, delta, 6 zero bits
    input  wire logic [79:0] s_axis_tdata,
    // opcode
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // event_id, fire_count, remaining, status, 6 zero bits
    output logic [79:0]      m_axis_tdata,
    // kind
    output logic [1:0]       m_axis_tuser,
    output logic             m_axis_tlast
);
    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic [IW-1:0] idx;
    logic [31:0] delta;
    logic        t_running, t_fires, t_notify, t_div;
    logic [32:0] t_count;
    logic [31:0] t_remaining, q_remaining;
    logic        wr_start, wr_stop;
    logic [73:0] out_data;
    kind_t       out_kind;

    mctb_ctrl #(.NUM_TIMERS(NUM_TIMERS)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_op(s_axis_tuser), .in_id(s_axis_tdata[7:0]),
        .in_delta(s_axis_tdata[73:42]),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_data(out_data), .out_kind(out_kind), .out_last(m_axis_tlast),
        .cmd(cmd), .stat(stat), .idx(idx), .delta(delta),
        .t_running(t_running), .t_fires(t_fires), .t_notify(t_notify), .t_div(t_div),
        .t_count(t_count), .t_remaining(t_remaining),
        .wr_start(wr_start), .wr_stop(wr_stop), .q_remaining(q_remaining)
    );

    mctb_datapath #(.NUM_TIMERS(NUM_TIMERS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .idx(idx), .delta(delta), .stat(stat),
        .t_running(t_running), .t_fires(t_fires), .t_notify(t_notify), .t_div(t_div),
        .t_count(t_count), .t_remaining(t_remaining),
        .wr_start(wr_start), .wr_stop(wr_stop), .wr_period(s_axis_tdata[39:8]),
        .wr_repeat(s_axis_tdata[40]), .wr_notify(s_axis_tdata[41]),
        .q_remaining(q_remaining)
    );

    assign m_axis_tdata = {6'd0, out_data};
    assign m_axis_tuser = out_kind;

    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.commit && (wr_start || wr_stop)))
        else $error("commit overlaps a command write");
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !stat.div_busy)
        else $error("divider started while busy");
    a_fire_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_FIRE) |-> !m_axis_tlast)
        else $error("fire event marked last");
endmodule
`default_nettype wire
